/* rtl/aot_pkg.sv */
// ---------------------------------------------------------------------------
// aot_pkg: shared definitions for the arctan overdrive tone core
// Holds the fixed-point constants, the soft-clip table, the queue entry
// and configuration types, and the saturation helper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package aot_pkg;

   // Soft-clip table geometry. The table spans magnitudes 0.0 to 32.0.
   localparam int ATAN_TABLE_DEPTH = 256;
   localparam int ATAN_DEPTH_LOG2  = $clog2(ATAN_TABLE_DEPTH);
   localparam int TAB_IDX_W        = ATAN_DEPTH_LOG2 + 1;
   localparam int SPAN_LOG2        = 5;
   localparam int POS_BITS         = 23 + SPAN_LOG2;
   localparam int FRAC_W           = POS_BITS - ATAN_DEPTH_LOG2;
   localparam int CORDIC_STEPS     = 32;
   localparam int FULL_Q23         = 8388608;
   localparam logic [63:0] TWO_OVER_PI_Q32 = 64'hA2F9836E;

   // Shared multiplier of the back end: a signed 25-bit operand times a
   // signed operand wide enough for the interpolation fraction and the
   // Q0.16 coefficients.
   localparam int MUL_A_W = 25;
   localparam int MUL_B_W = (FRAC_W + 1 > 18) ? FRAC_W + 1 : 18;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = PROD_W + 1;

   // Front end prescale product: 24-bit sample times 22-bit drive.
   localparam int PRE_PROD_W = 46;
   localparam int PRE_W      = PRE_PROD_W - 16;

   // Queue between the front and the back end.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [23:0] atan_tab_type [0:ATAN_TABLE_DEPTH];

   typedef struct packed {
      logic                       neg;
      logic [ATAN_DEPTH_LOG2-1:0] idx;
      logic [FRAC_W-1:0]          frac;
      logic                       channel;
      logic                       last;
   } queue_entry_type;

   typedef struct packed {
      logic [20:0] drive;
      logic [15:0] tone_coeff;
      logic [16:0] level;
   } cfg_type;

   // Unsigned 64-bit quotient by shift and subtract. Only the table
   // builder and atan_inv_q60 call it, so it is evaluated at elaboration.
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [64:0] r;
      q = 64'd0;
      r = 65'd0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], n[b]};
         if (r >= {1'b0, d}) begin
            r    = r - {1'b0, d};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // atan(1/m) in radians, Q60, by the alternating series.
   function automatic logic [63:0] atan_inv_q60(input logic [63:0] m);
      logic [63:0] p;
      logic [63:0] sum;
      logic [63:0] n;
      logic [63:0] t;
      p   = udiv64(64'd1 << 60, m);
      sum = 64'd0;
      n   = 64'd0;
      while (p != 64'd0) begin
         t = udiv64(p, 64'd2 * n + 64'd1);
         if (n[0]) begin
            sum = sum - t;
         end else begin
            sum = sum + t;
         end
         p = udiv64(p, m * m);
         n = n + 64'd1;
      end
      return sum;
   endfunction

   // Builds the soft-clip table at elaboration. Points above 1.0 use
   // 1 - (2/pi)*atan(1/u).
   function automatic atan_tab_type build_atan_tab();
      atan_tab_type       tab;
      logic signed [63:0] ang [CORDIC_STEPS];
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] z;
      logic signed [63:0] dx;
      logic signed [63:0] dy;
      logic [63:0]        num;
      logic [63:0]        v;
      logic [63:0]        q;
      logic [63:0]        f;
      ang[0] = $signed((atan_inv_q60(64'd2) + atan_inv_q60(64'd3) + (64'd1 << 27)) >> 28);
      for (int j = 1; j < CORDIC_STEPS; j++) begin
         ang[j] = $signed((atan_inv_q60(64'd1 << j) + (64'd1 << 27)) >> 28);
      end
      for (int i = 0; i <= ATAN_TABLE_DEPTH; i++) begin
         num = 64'(i) << SPAN_LOG2;
         if (num <= 64'(ATAN_TABLE_DEPTH)) begin
            v = (num << 30) >> ATAN_DEPTH_LOG2;
         end else begin
            v = udiv64(64'(ATAN_TABLE_DEPTH) << 30, num);
         end
         x = 64'sd1 << 30;
         y = $signed(v);
         z = 64'sd0;
         for (int j = 0; j < CORDIC_STEPS; j++) begin
            dx = y >>> j;
            dy = x >>> j;
            if (y >= 0) begin
               x = x + dx;
               y = y - dy;
               z = z + ang[j];
            end else begin
               x = x - dx;
               y = y + dy;
               z = z - ang[j];
            end
         end
         if (z < 0) begin
            z = 64'sd0;
         end
         q = $unsigned(z) * TWO_OVER_PI_Q32;
         q = q >> 32;
         f = (q + 64'd256) >> 9;
         if (num <= 64'(ATAN_TABLE_DEPTH)) begin
            tab[i] = $signed(f[23:0]);
         end else begin
            tab[i] = $signed(24'(64'(FULL_Q23) - f));
         end
      end
      return tab;
   endfunction

   localparam atan_tab_type ATAN_TAB = build_atan_tab();

   localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(FULL_Q23 - 1);
   localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(FULL_Q23);

   function automatic logic signed [23:0] sat24(input logic signed [ACC_W-1:0] v);
      logic signed [23:0] r;
      if (v > SAT_MAX) begin
         r = 24'sh7FFFFF;
      end else if (v < SAT_MIN) begin
         r = 24'sh800000;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

endpackage

/* rtl/aot_front.sv */
// ---------------------------------------------------------------------------
// aot_front: input beat capture and prescale
// Takes a beat, multiplies the sample by the drive, splits the magnitude
// into table index and interpolation fraction, and pushes the entry.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aot_front (
   input  logic                      clock,
   input  logic                      reset,
   input  aot_pkg::cfg_type          cfg,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [23:0]        req_sample,
   input  logic                      req_channel,
   input  logic                      req_end_of_block,
   input  logic                      q_full,
   output logic                      push,
   output aot_pkg::queue_entry_type  push_data
);

   typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} front_state_type;

   front_state_type                          state_ff;
   logic signed [23:0]                       sample_ff;
   logic                                     channel_ff;
   logic                                     last_ff;
   logic signed [aot_pkg::PRE_PROD_W-1:0]    prod_ff;
   logic signed [aot_pkg::PRE_PROD_W-1:0]    prod_in;
   logic signed [aot_pkg::PRE_W-1:0]         pre;
   logic signed [aot_pkg::PRE_W-1:0]         mag_full;
   logic [aot_pkg::POS_BITS-1:0]             mag;

   assign req_ready = (state_ff == F_IDLE) && !reset;
   assign prod_in   = aot_pkg::PRE_PROD_W'(sample_ff)
                    * aot_pkg::PRE_PROD_W'($signed({1'b0, cfg.drive}));

   // Floor of the product by 2^16 is an arithmetic shift.
   assign pre      = prod_ff[aot_pkg::PRE_PROD_W-1:16];
   assign mag_full = pre[aot_pkg::PRE_W-1] ? -pre : pre;
   assign mag      = mag_full[aot_pkg::POS_BITS-1:0];

   assign push              = (state_ff == F_PUSH) && !q_full;
   assign push_data.neg     = pre[aot_pkg::PRE_W-1];
   assign push_data.idx     = mag[aot_pkg::POS_BITS-1:aot_pkg::FRAC_W];
   assign push_data.frac    = mag[aot_pkg::FRAC_W-1:0];
   assign push_data.channel = channel_ff;
   assign push_data.last    = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (req_valid) begin
                  state_ff   <= F_MUL;
                  sample_ff  <= req_sample;
                  channel_ff <= req_channel;
                  last_ff    <= req_end_of_block;
               end
            end
            F_MUL: begin
               prod_ff  <= prod_in;
               state_ff <= F_PUSH;
            end
            F_PUSH: begin
               if (!q_full) begin
                  state_ff <= F_IDLE;
               end
            end
            default: begin
               state_ff <= F_IDLE;
            end
         endcase
      end
   end

endmodule

/* rtl/aot_queue.sv */
// ---------------------------------------------------------------------------
// aot_queue: short queue between front and back end
// Holds prescaled entries so that each side can stall on its own.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aot_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  aot_pkg::queue_entry_type  push_data,
   input  logic                      pop,
   output aot_pkg::queue_entry_type  pop_data,
   output logic                      full,
   output logic                      empty
);

   aot_pkg::queue_entry_type              mem_ff [aot_pkg::QUEUE_DEPTH];
   logic [aot_pkg::QUEUE_PTR_W-1:0]       wr_ptr_ff;
   logic [aot_pkg::QUEUE_PTR_W-1:0]       rd_ptr_ff;
   logic [aot_pkg::QUEUE_CNT_W-1:0]       count_ff;
   logic [aot_pkg::QUEUE_PTR_W-1:0]       wr_ptr_in;
   logic [aot_pkg::QUEUE_PTR_W-1:0]       rd_ptr_in;

   localparam logic [aot_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
      aot_pkg::QUEUE_PTR_W'(aot_pkg::QUEUE_DEPTH - 1);

   assign full     = (count_ff == aot_pkg::QUEUE_CNT_W'(aot_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue pushed while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("queue popped while empty");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= aot_pkg::QUEUE_CNT_W'(aot_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule

/* rtl/aot_back.sv */
// ---------------------------------------------------------------------------
// aot_back: soft clip, tone filter and level stage
// Sequences one shared multiplier through interpolation, the one-pole
// lowpass and the level scaling, and holds the result beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module aot_back (
   input  logic                      clock,
   input  logic                      reset,
   input  aot_pkg::cfg_type          cfg,
   input  logic                      q_empty,
   input  aot_pkg::queue_entry_type  q_data,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [23:0]        rsp_out_sample,
   output logic                      rsp_out_channel,
   output logic                      rsp_last
);

   typedef enum logic [3:0] {
      B_IDLE, B_TAB, B_INTERP, B_CLIP, B_MUL1, B_MUL2, B_FILT, B_LEVEL, B_OUT
   } back_state_type;

   localparam int ACC_W   = aot_pkg::ACC_W;
   localparam int PROD_W  = aot_pkg::PROD_W;
   localparam int MUL_B_W = aot_pkg::MUL_B_W;
   localparam int FRAC_W  = aot_pkg::FRAC_W;

   back_state_type                     state_ff;
   aot_pkg::queue_entry_type           ent_ff;
   logic signed [23:0]                 lo_ff;
   logic signed [23:0]                 hi_ff;
   logic signed [23:0]                 clip_ff;
   logic signed [23:0]                 st_ff;
   logic signed [PROD_W-1:0]           prod_ff;
   logic signed [ACC_W-1:0]            acc_ff;
   logic signed [23:0]                 filt_ff [2];
   logic                               rsp_valid_ff;
   logic signed [23:0]                 rsp_sample_ff;
   logic                               rsp_channel_ff;
   logic                               rsp_last_ff;

   logic signed [aot_pkg::MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0]          mul_b;
   logic signed [PROD_W-1:0]           mul_p;
   logic [aot_pkg::TAB_IDX_W-1:0]      lo_idx;
   logic [aot_pkg::TAB_IDX_W-1:0]      hi_idx;
   logic signed [25:0]                 y_w;
   logic signed [25:0]                 y_n;
   logic signed [23:0]                 clip_in;
   logic signed [ACC_W-1:0]            prod_ext;
   logic signed [ACC_W-1:0]            filt_sum;
   logic signed [23:0]                 st_in;
   logic signed [ACC_W-1:0]            out_sum;
   logic signed [23:0]                 out_in;
   logic [16:0]                        one_minus_a;
   logic                               slot_free;

   assign pop       = (state_ff == B_IDLE) && !q_empty;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign lo_idx = {1'b0, ent_ff.idx};
   assign hi_idx = {1'b0, ent_ff.idx} + 1'b1;

   assign one_minus_a = 17'h10000 - {1'b0, cfg.tone_coeff};

   always_comb begin
      unique case (state_ff)
         B_INTERP: begin
            mul_a = {hi_ff[23], hi_ff} - {lo_ff[23], lo_ff};
            mul_b = $signed({{(MUL_B_W - FRAC_W){1'b0}}, ent_ff.frac});
         end
         B_MUL1: begin
            mul_a = {clip_ff[23], clip_ff};
            mul_b = $signed({{(MUL_B_W - 17){1'b0}}, one_minus_a});
         end
         B_MUL2: begin
            mul_a = {filt_ff[ent_ff.channel][23], filt_ff[ent_ff.channel]};
            mul_b = $signed({{(MUL_B_W - 16){1'b0}}, cfg.tone_coeff});
         end
         B_LEVEL: begin
            mul_a = {st_ff[23], st_ff};
            mul_b = $signed({{(MUL_B_W - 17){1'b0}}, cfg.level});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Interpolated clip: the floored step is the product shifted by the
   // fraction width, and the sign of the prescaled sample is put back.
   assign y_w     = {{2{lo_ff[23]}}, lo_ff} + prod_ff[FRAC_W +: 26];
   assign y_n     = ent_ff.neg ? -y_w : y_w;
   assign clip_in = aot_pkg::sat24({{(ACC_W - 26){y_n[25]}}, y_n});

   assign prod_ext = {prod_ff[PROD_W-1], prod_ff};
   assign filt_sum = acc_ff + prod_ext + ACC_W'(32768);
   assign st_in    = aot_pkg::sat24(filt_sum >>> 16);
   assign out_sum  = prod_ext + ACC_W'(32768);
   assign out_in   = aot_pkg::sat24(out_sum >>> 16);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         filt_ff[0]   <= '0;
         filt_ff[1]   <= '0;
      end else begin
         // In the result step a taken beat is replaced by the new one below.
         if (rsp_valid_ff && rsp_ready && (state_ff != B_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            B_IDLE: begin
               if (!q_empty) begin
                  ent_ff   <= q_data;
                  state_ff <= B_TAB;
               end
            end
            B_TAB: begin
               lo_ff    <= aot_pkg::ATAN_TAB[lo_idx];
               hi_ff    <= aot_pkg::ATAN_TAB[hi_idx];
               state_ff <= B_INTERP;
            end
            B_INTERP: begin
               prod_ff  <= mul_p;
               state_ff <= B_CLIP;
            end
            B_CLIP: begin
               clip_ff  <= clip_in;
               state_ff <= B_MUL1;
            end
            B_MUL1: begin
               prod_ff  <= mul_p;
               state_ff <= B_MUL2;
            end
            B_MUL2: begin
               acc_ff   <= prod_ext;
               prod_ff  <= mul_p;
               state_ff <= B_FILT;
            end
            B_FILT: begin
               filt_ff[ent_ff.channel] <= st_in;
               st_ff                   <= st_in;
               state_ff                <= B_LEVEL;
            end
            B_LEVEL: begin
               prod_ff  <= mul_p;
               state_ff <= B_OUT;
            end
            B_OUT: begin
               if (slot_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_sample_ff  <= out_in;
                  rsp_channel_ff <= ent_ff.channel;
                  rsp_last_ff    <= ent_ff.last;
                  state_ff       <= B_IDLE;
               end
            end
            default: begin
               state_ff <= B_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_sample  = rsp_sample_ff;
   assign rsp_out_channel = rsp_channel_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTHESIS
   a_filter_only_in_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff != B_FILT) |=> ($stable(filt_ff[0]) && $stable(filt_ff[1])))
      else $error("filter state changed outside the update step");

   a_hold_while_slot_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_OUT && !slot_free) |=> (state_ff == B_OUT))
      else $error("result step left while the output beat was still held");

   a_rsp_held_until_taken: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_sample_ff)
         && $stable(rsp_channel_ff) && $stable(rsp_last_ff)))
      else $error("response beat changed before it was taken");
`endif

endmodule

/* rtl/arctan_overdrive_tone_core.sv */
// ---------------------------------------------------------------------------
// arctan_overdrive_tone_core: arctan soft-clip overdrive with tone lowpass
// Each request beat carries one Q1.23 sample of channel 0 or 1. The sample
// is scaled by drive = 1 + 20*gain, soft clipped by an interpolated arctan
// table, filtered by a one-pole lowpass with one state per channel, and
// scaled by level; one response beat comes out per request beat, in order.
// The front end captures a beat, does the prescale multiply and pushes
// it into a two-entry queue (capture, prescale multiply, queue push); it
// takes no new beat before that push, which waits while the queue is full.
// The back end works on one item at a time with its single shared
// multiplier, which is used in turn for the interpolation, both filter
// products and the level scaling, and waits while a result beat is held.
// Registers lie at byte addresses 0 (gain), 4 (tone_coeff) and 8 (level);
// gain and level above 65536 act as 65536. Register writes reach the
// datapath through the registered configuration copy.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module arctan_overdrive_tone_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [23:0] req_sample,
   input  logic               req_channel,
   input  logic               req_end_of_block,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [23:0] rsp_out_sample,
   output logic               rsp_out_channel,
   output logic               rsp_last,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam logic [1:0] REG_GAIN  = 2'd0;
   localparam logic [1:0] REG_TONE  = 2'd1;
   localparam logic [1:0] REG_LEVEL = 2'd2;

   logic [16:0]              gain_ff;
   logic [15:0]              tone_ff;
   logic [16:0]              level_ff;
   aot_pkg::cfg_type         cfg_ff;
   aot_pkg::cfg_type         cfg_in;
   logic [16:0]              gain_sat;
   logic [1:0]               reg_index;
   logic                     csr_write;

   logic                     q_push;
   logic                     q_pop;
   logic                     q_full;
   logic                     q_empty;
   aot_pkg::queue_entry_type q_push_data;
   aot_pkg::queue_entry_type q_pop_data;

   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= 17'd32768;
         tone_ff  <= 16'd37573;
         level_ff <= 17'd45875;
      end else if (csr_write) begin
         unique case (reg_index)
            REG_GAIN:  gain_ff  <= pwdata[16:0];
            REG_TONE:  tone_ff  <= pwdata[15:0];
            REG_LEVEL: level_ff <= pwdata[16:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_GAIN:  prdata = {15'd0, gain_ff};
         REG_TONE:  prdata = {16'd0, tone_ff};
         REG_LEVEL: prdata = {15'd0, level_ff};
         default:   prdata = 32'd0;
      endcase
   end

   // Derived coefficients are registered to keep the add off the
   // prescale multiplier path.
   assign gain_sat          = (gain_ff > 17'h10000) ? 17'h10000 : gain_ff;
   assign cfg_in.drive      = 21'h10000 + {gain_sat, 4'b0000} + {2'b00, gain_sat, 2'b00};
   assign cfg_in.tone_coeff = tone_ff;
   assign cfg_in.level      = (level_ff > 17'h10000) ? 17'h10000 : level_ff;

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   aot_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .req_channel      (req_channel),
      .req_end_of_block (req_end_of_block),
      .q_full           (q_full),
      .push             (q_push),
      .push_data        (q_push_data)
   );

   aot_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   aot_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_empty         (q_empty),
      .q_data          (q_pop_data),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_sample  (rsp_out_sample),
      .rsp_out_channel (rsp_out_channel),
      .rsp_last        (rsp_last)
   );

endmodule
